// ===== sv/wpw_pkg.sv =====
// Shared types and constants for the window pixel writer.
// Depends on nothing; used by every module of the block.
`default_nettype none
package wpw_pkg;

    localparam int LINE_WIDTH = 480;

    localparam int DATA_W  = 32;
    localparam int COORD_W = 12;
    localparam int POS_W   = COORD_W + 1;
    localparam int LW_W    = $clog2(LINE_WIDTH + 1);
    localparam int PROD_W  = POS_W + LW_W;
    localparam int BOFF_W  = PROD_W + 2;
    localparam int COLOR_W = 24;
    localparam int PIX_W   = 16;
    localparam int ADDR_W  = 5;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_FRAME_BASE    = 3'd0;
    localparam logic [IDX_W-1:0] REG_WINDOW_LEFT   = 3'd1;
    localparam logic [IDX_W-1:0] REG_WINDOW_TOP    = 3'd2;
    localparam logic [IDX_W-1:0] REG_WINDOW_RIGHT  = 3'd3;
    localparam logic [IDX_W-1:0] REG_WINDOW_BOTTOM = 3'd4;

    typedef struct packed {
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] bottom;
        logic               restart;
    } t_win;

    typedef struct packed {
        logic               valid;
        logic [COLOR_W-1:0] color;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
    } t_s1;

endpackage
`default_nettype wire

// ===== sv/wpw_cfg.sv =====
// APB register file: frame base and window corners.
// Depends on wpw_pkg; flags a window restart on any corner write.
`default_nettype none
module wpw_cfg (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [wpw_pkg::ADDR_W-1:0] paddr,
    input  wire logic [wpw_pkg::DATA_W-1:0] pwdata,
    output logic      [wpw_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output logic      [wpw_pkg::DATA_W-1:0] o_frame_base,
    output wpw_pkg::t_win                   o_win
);

    logic [wpw_pkg::DATA_W-1:0]  r_base;
    logic [wpw_pkg::COORD_W-1:0] r_left, r_top, r_right, r_bottom;
    logic [wpw_pkg::IDX_W-1:0]   idx;
    logic                        wr;

    assign pready = 1'b1;
    assign idx    = paddr[wpw_pkg::ADDR_W-1:2];
    assign wr     = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= '0;
            r_left    <= '0;
            r_top     <= '0;
            r_right   <= '0;
            r_bottom  <= '0;
        end else begin
            if (wr) begin
                case (idx)
                    wpw_pkg::REG_FRAME_BASE:    r_base   <= pwdata;
                    wpw_pkg::REG_WINDOW_LEFT:   r_left   <= pwdata[wpw_pkg::COORD_W-1:0];
                    wpw_pkg::REG_WINDOW_TOP:    r_top    <= pwdata[wpw_pkg::COORD_W-1:0];
                    wpw_pkg::REG_WINDOW_RIGHT:  r_right  <= pwdata[wpw_pkg::COORD_W-1:0];
                    wpw_pkg::REG_WINDOW_BOTTOM: r_bottom <= pwdata[wpw_pkg::COORD_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        case (idx)
            wpw_pkg::REG_FRAME_BASE:    prdata = r_base;
            wpw_pkg::REG_WINDOW_LEFT:   prdata = wpw_pkg::DATA_W'(r_left);
            wpw_pkg::REG_WINDOW_TOP:    prdata = wpw_pkg::DATA_W'(r_top);
            wpw_pkg::REG_WINDOW_RIGHT:  prdata = wpw_pkg::DATA_W'(r_right);
            wpw_pkg::REG_WINDOW_BOTTOM: prdata = wpw_pkg::DATA_W'(r_bottom);
            default:                    prdata = '0;
        endcase
    end

    assign o_frame_base  = r_base;
    assign o_win.left    = r_left;
    assign o_win.top     = r_top;
    assign o_win.right   = r_right;
    assign o_win.bottom  = r_bottom;
    assign o_win.restart = wr && (idx inside {wpw_pkg::REG_WINDOW_LEFT, wpw_pkg::REG_WINDOW_TOP,
                                              wpw_pkg::REG_WINDOW_RIGHT,
                                              wpw_pkg::REG_WINDOW_BOTTOM});

endmodule
`default_nettype wire

// ===== sv/wpw_walk.sv =====
// Raster walk over the window and input stage register.
// Depends on wpw_pkg; decides write or drop for each accepted word.
`default_nettype none
module wpw_walk (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire wpw_pkg::t_win               i_win,
    input  wire logic                        i_advance,
    input  wire logic                        i_accept,
    input  wire logic [wpw_pkg::COLOR_W-1:0] i_color,
    output wpw_pkg::t_s1                     o_s1
);

    logic [wpw_pkg::COORD_W-1:0] r_col, r_row, n_col, n_row;
    logic                        r_full, n_full;
    logic                        empty, last_col, last_row, wr;
    wpw_pkg::t_s1                r_s1;

    assign empty    = (i_win.right < i_win.left) || (i_win.bottom < i_win.top);
    assign last_col = r_col >= (i_win.right - i_win.left);
    assign last_row = r_row >= (i_win.bottom - i_win.top);
    assign wr       = i_accept & ~empty & ~r_full;

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_full = r_full;
        if (i_win.restart) begin
            n_col  = '0;
            n_row  = '0;
            n_full = 1'b0;
        end else if (i_accept && !empty) begin
            if (r_full) begin
                n_col  = '0;
                n_row  = '0;
                n_full = 1'b0;
            end else if (last_col) begin
                n_col = '0;
                if (last_row) begin
                    n_row  = '0;
                    n_full = 1'b1;
                end else begin
                    n_row = r_row + wpw_pkg::COORD_W'(1);
                end
            end else begin
                n_col = r_col + wpw_pkg::COORD_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_full     <= 1'b0;
            r_s1.valid <= 1'b0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_full <= n_full;
            if (i_advance) begin
                r_s1.valid <= wr;
                r_s1.color <= i_color;
                r_s1.x     <= {1'b0, i_win.left} + {1'b0, r_col};
                r_s1.y     <= {1'b0, i_win.top} + {1'b0, r_row};
            end
        end
    end

    assign o_s1 = r_s1;

endmodule
`default_nettype wire

// ===== sv/wpw_addr.sv =====
// Address and RGB565 stage with the result register.
// Depends on wpw_pkg; fed by the walk stage register.
`default_nettype none
module wpw_addr (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_advance,
    input  wire wpw_pkg::t_s1               i_s1,
    input  wire logic [wpw_pkg::DATA_W-1:0] i_frame_base,
    output logic                            o_valid,
    output logic      [wpw_pkg::DATA_W-1:0] o_address,
    output logic      [wpw_pkg::PIX_W-1:0]  o_pixel
);

    logic [wpw_pkg::PROD_W-1:0] prod;
    logic [wpw_pkg::PROD_W:0]   pix_off;
    logic [wpw_pkg::BOFF_W-1:0] byte_off;
    logic [wpw_pkg::DATA_W-1:0] r_address;
    logic [wpw_pkg::PIX_W-1:0]  r_pixel;
    logic                       r_valid;

    assign prod     = wpw_pkg::PROD_W'(i_s1.y) * wpw_pkg::PROD_W'(wpw_pkg::LINE_WIDTH);
    assign pix_off  = {1'b0, prod} + (wpw_pkg::PROD_W + 1)'(i_s1.x);
    assign byte_off = {pix_off, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_s1.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_address <= i_frame_base + wpw_pkg::DATA_W'(byte_off);
            r_pixel   <= {i_s1.color[23:19], i_s1.color[15:10], i_s1.color[7:3]};
        end
    end

    assign o_valid   = r_valid;
    assign o_address = r_address;
    assign o_pixel   = r_pixel;

endmodule
`default_nettype wire

// ===== sv/window_pixel_writer_rgb565.sv =====
// Window pixel writer, top level: APB registers, walk stage, address stage.
// Depends on wpw_pkg, wpw_cfg, wpw_walk and wpw_addr.
//
//  channel   direction  width  contents
//  s_axis    in         24     pixel_color (RGB888)
//  m_axis    out        48     mem_address [31:0], pixel_data [47:32]
//  apb       in/out     32     frame_base, window_left/top/right/bottom
//
// One word per cycle unless stalled; a word passes the walk and result registers.
// Position counters step in the cycle a word is taken; dropped words give no result.
// The two stages stall together while a result waits with m_axis_tready low.
// Synchronous active-low reset clears the APB registers, valid flags and position.
`default_nettype none
module window_pixel_writer_rgb565 (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [23:0]                 s_axis_tdata,  // pixel_color
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic      [47:0]                 m_axis_tdata,  // mem_address, pixel_data
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [wpw_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [wpw_pkg::DATA_W-1:0]  pwdata,
    output logic      [wpw_pkg::DATA_W-1:0]  prdata,
    output logic                             pready
);

    logic [wpw_pkg::DATA_W-1:0] frame_base;
    wpw_pkg::t_win              win;
    wpw_pkg::t_s1               s1;
    logic                       advance;
    logic [wpw_pkg::DATA_W-1:0] address;
    logic [wpw_pkg::PIX_W-1:0]  pixel;

    assign advance       = ~m_axis_tvalid | m_axis_tready;
    assign s_axis_tready = advance & i_rst_n;

    wpw_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_frame_base(frame_base),
        .o_win       (win)
    );

    wpw_walk u_walk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_win    (win),
        .i_advance(advance),
        .i_accept (s_axis_tvalid & s_axis_tready),
        .i_color  (s_axis_tdata),
        .o_s1     (s1)
    );

    wpw_addr u_addr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_s1        (s1),
        .i_frame_base(frame_base),
        .o_valid     (m_axis_tvalid),
        .o_address   (address),
        .o_pixel     (pixel)
    );

    assign m_axis_tdata = {pixel, address};

endmodule
`default_nettype wire
